// File: hdl/fmrsp_pkg.sv
// Package: shared types, codes and field helpers for the FM register shadow capture block.
package fmrsp_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int OP_W = 43;
  localparam int CH_W = 6;
  localparam int NUM_CH = 6;
  localparam int NUM_SLOT = 24;
  localparam int SLOT_AW = 5;

  localparam logic [7:0] REG_DAC = 8'h2b;
  localparam logic [7:0] REG_KEY = 8'h28;
  localparam logic [7:0] REG_LO = 8'h30;
  localparam logic [7:0] REG_HI = 8'hb3;
  localparam logic [3:0] GRP_CHAN = 4'hb;
  localparam logic [6:0] LEVEL_MAX = 7'h7e;
  localparam logic [2:0] CH_DAC = 3'd5;

  typedef enum logic [2:0] {
    EV_STORED = 3'd0,
    EV_IGNORED = 3'd1,
    EV_UNCHANGED = 3'd2,
    EV_MATCHED = 3'd3,
    EV_ADDED = 3'd4,
    EV_SILENT = 3'd5,
    EV_FULL = 3'd6
  } event_t;

  typedef enum logic [2:0] {
    WK_IGN,
    WK_DAC,
    WK_KEY,
    WK_CHAN,
    WK_OP
  } wkind_t;

  typedef struct packed {
    wkind_t kind;
    logic [2:0] ch;
    logic [SLOT_AW-1:0] slot;
    logic [3:0] grp;
    logic key_bad;
  } dec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHRD,
    S_SHWR,
    S_KRD,
    S_KDEC,
    S_SRCH,
    S_APP,
    S_OUT
  } state_t;

  // detune codes 4..7 fold to 0,-1,-2,-3 (three-bit two's complement)
  function automatic logic [2:0] dt_map(input logic [2:0] c);
    logic [2:0] r;
    if (c[2] == 1'b0) begin
      r = c;
    end else begin
      r = 3'(3'd0 - {1'b0, c[1:0]});
    end
    return r;
  endfunction

  function automatic logic [OP_W-1:0] op_merge(input logic [OP_W-1:0] w,
                                               input logic [3:0] grp,
                                               input logic [7:0] v);
    logic [OP_W-1:0] r;
    r = w;
    unique case (grp)
      4'h3: begin
        r[2:0] = dt_map(v[6:4]);
        r[6:3] = v[3:0];
      end
      4'h4: r[13:7] = v[6:0];
      4'h5: begin
        r[15:14] = v[7:6];
        r[20:16] = v[4:0];
      end
      4'h6: r[25:21] = v[4:0];
      4'h7: r[30:26] = v[4:0];
      4'h8: begin
        r[38:35] = v[7:4];
        r[34:31] = v[3:0];
      end
      4'h9: r[42:39] = v[3:0];
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/fmrsp_ram.sv
// Generic single-port-write, registered-read RAM.
module fmrsp_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = $clog2(D > 1 ? D : 2)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/fmrsp_decode.sv
// Register write decoder: classifies one write and derives channel and slot.
module fmrsp_decode (
  input  logic            bank,
  input  logic [7:0]      register_address,
  input  logic [7:0]      write_value,
  output fmrsp_pkg::dec_t dec
);
  import fmrsp_pkg::*;

  logic [2:0] op_ch;
  logic [2:0] key_ch;

  assign op_ch = 3'(register_address[1:0]) + (bank ? 3'd3 : 3'd0);
  assign key_ch = write_value[2] ? 3'(3'd3 + 3'(write_value[1:0]))
                                 : {1'b0, write_value[1:0]};

  always_comb begin
    dec.grp = register_address[7:4];
    dec.slot = {op_ch, register_address[3:2]};
    dec.ch = op_ch;
    dec.key_bad = (write_value[1:0] == 2'd3) || (write_value[7:4] == 4'd0);
    priority if (!bank && register_address == REG_DAC) begin
      dec.kind = WK_DAC;
    end else if (!bank && register_address == REG_KEY) begin
      dec.kind = WK_KEY;
      dec.ch = key_ch;
    end else if (register_address < REG_LO || register_address > REG_HI ||
                 register_address[1:0] == 2'd3) begin
      dec.kind = WK_IGN;
    end else if (register_address[7:4] == GRP_CHAN) begin
      dec.kind = WK_CHAN;
    end else if (register_address[7:4] == 4'ha) begin
      dec.kind = WK_IGN;
    end else begin
      dec.kind = WK_OP;
    end
  end

endmodule

// File: hdl/fm_register_shadow_patch_capture_top.sv
// Top level: FM register shadow, key-on patch compare and capture table.
//
//  channel | dir | ports                                         | handshake
//  --------+-----+-----------------------------------------------+------------
//  in      | in  | in_bank, in_register_address, in_write_value   | valid/stall
//  out     | out | out_event_res, out_entry_index, out_entry_count| valid/stall
//
// One word at a time. Ignored, DAC and channel writes go straight to the result;
// operator writes do a read-modify-write of the operator shadow RAM. A valid key-on
// reads the channel's four shadow words, then searches the table for a changed,
// audible patch, stopping on a hit; the scan reads one 43-bit operator word per
// cycle from the capture RAM. The key-on then refreshes the channel snapshot.
// Reset (synchronous, rst_n low) clears control, valid bits, DAC flag and
// count; RAM contents are left as they are, no clearing pass.
// A stalled result waits in the output register; the next word is taken
// meanwhile and its result waits until the register frees.
module fm_register_shadow_patch_capture_top #(
  parameter int TABLE_ENTRIES = fmrsp_pkg::TABLE_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_bank,
  input  logic [7:0] in_register_address,
  input  logic [7:0] in_write_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_event_res,
  output logic [5:0] out_entry_index,
  output logic [6:0] out_entry_count
);
  import fmrsp_pkg::*;

  localparam int EW = $clog2(TABLE_ENTRIES > 1 ? TABLE_ENTRIES : 2);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int IW = EW + 3;
  localparam int IXW = EW > 6 ? EW : 6;
  localparam int CXW = CW > 7 ? CW : 7;

  state_t state_r, state_nxt;
  dec_t   dec;

  logic [2:0]          ch_r;
  logic [SLOT_AW-1:0]  slot_r;
  logic [3:0]          grp_r;
  logic [7:0]          val_r;
  logic [2:0]          cnt_r;
  logic [OP_W-1:0]     opw_r [4];
  logic                eq_r, noatk_r, quiet_r, app_r;
  logic [CH_W-1:0]     chan_sh_r [NUM_CH];
  logic [CH_W-1:0]     chan_snap_r [NUM_CH];
  logic [NUM_CH-1:0]   snap_vld_r;
  logic [NUM_SLOT-1:0] sh_vld_r;
  logic                shv_q_r;
  logic                dac_r;
  logic [CW-1:0]       count_r;
  event_t              res_r;
  logic [EW-1:0]       idx_r;
  logic [IW-1:0]       iss_r;
  logic                chk_vld_r;
  logic [EW+1:0]       chk_addr_r;
  logic                ok_r;

  logic                out_valid_r;
  logic [2:0]          out_res_r;
  logic [5:0]          out_idx_r;
  logic [6:0]          out_cnt_r;

  // RAM ports
  logic                sh_we;
  logic [SLOT_AW-1:0]  sh_waddr, sh_raddr;
  logic [OP_W-1:0]     sh_wdata, sh_rdata, sh_word;
  logic                sn_we;
  logic [SLOT_AW-1:0]  sn_addr_w;
  logic [OP_W-1:0]     sn_rdata;
  logic                cap_we;
  logic [EW+1:0]       cap_waddr;
  logic [OP_W-1:0]     cap_rdata;
  logic                cw_we;
  logic [CH_W-1:0]     cw_rdata;

  logic                in_acc;
  logic                out_free;
  logic [IW-1:0]       limit;
  logic                issue;
  logic                op_eq, hit, scan_done;
  logic [1:0]          rd_word;
  logic [IXW-1:0]      idx_ext;
  logic [CXW-1:0]      cnt_ext;

  fmrsp_decode u_dec (
    .bank             (in_bank),
    .register_address (in_register_address),
    .write_value      (in_write_value),
    .dec              (dec)
  );

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign limit    = IW'({count_r, 2'b00});
  assign rd_word  = 2'(cnt_r - 3'd1);
  assign sh_word  = shv_q_r ? sh_rdata : '0;

  // search pipeline: issue one capture word per cycle, compare in the next cycle
  assign issue     = (state_r == S_SRCH) && (iss_r < limit) && !hit;
  assign op_eq     = cap_rdata == opw_r[chk_addr_r[1:0]];
  assign hit       = chk_vld_r && (chk_addr_r[1:0] == 2'd3) && ok_r && op_eq;
  assign scan_done = (iss_r >= limit) && !chk_vld_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (dec.kind)
            WK_OP:   state_nxt = S_SHRD;
            WK_KEY:  state_nxt = (dec.key_bad || (dec.ch == CH_DAC && dac_r)) ? S_OUT : S_KRD;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_SHRD: state_nxt = S_SHWR;
      S_SHWR: state_nxt = S_OUT;
      S_KRD:  state_nxt = (cnt_r == 3'd4) ? S_KDEC : S_KRD;
      S_KDEC: begin
        if ((snap_vld_r[ch_r] && eq_r) || noatk_r || quiet_r) begin
          state_nxt = S_APP;
        end else begin
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: state_nxt = (hit || scan_done) ? S_APP : S_SRCH;
      S_APP:  state_nxt = (cnt_r == 3'd3) ? S_OUT : S_APP;
      S_OUT:  state_nxt = out_free ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and RAM controls
  always_comb begin
    in_stall  = (state_r != S_IDLE);
    sh_we     = (state_r == S_SHWR);
    sh_waddr  = slot_r;
    sh_wdata  = op_merge(sh_word, grp_r, val_r);
    sh_raddr  = (state_r == S_IDLE) ? dec.slot :
                (state_r == S_KRD) ? {ch_r, cnt_r[1:0]} : slot_r;
    sn_we     = (state_r == S_APP);
    sn_addr_w = {ch_r, cnt_r[1:0]};
    cap_we    = (state_r == S_APP) && app_r;
    cap_waddr = {EW'(count_r), cnt_r[1:0]};
    cw_we     = cap_we && (cnt_r == 3'd3);
  end

  fmrsp_ram #(.W(OP_W), .D(NUM_SLOT)) u_shadow (
    .clk (clk), .we (sh_we), .waddr (sh_waddr), .wdata (sh_wdata),
    .raddr (sh_raddr), .rdata (sh_rdata)
  );

  fmrsp_ram #(.W(OP_W), .D(NUM_SLOT)) u_snap (
    .clk (clk), .we (sn_we), .waddr (sn_addr_w), .wdata (opw_r[cnt_r[1:0]]),
    .raddr ({ch_r, cnt_r[1:0]}), .rdata (sn_rdata)
  );

  fmrsp_ram #(.W(OP_W), .D(4 * TABLE_ENTRIES)) u_cap_op (
    .clk (clk), .we (cap_we), .waddr (cap_waddr), .wdata (opw_r[cnt_r[1:0]]),
    .raddr (iss_r[EW+1:0]), .rdata (cap_rdata)
  );

  fmrsp_ram #(.W(CH_W), .D(TABLE_ENTRIES)) u_cap_ch (
    .clk (clk), .we (cw_we), .waddr (EW'(count_r)), .wdata (chan_sh_r[ch_r]),
    .raddr (iss_r[EW+1:2]), .rdata (cw_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sh_vld_r    <= '0;
      snap_vld_r  <= '0;
      dac_r       <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      chk_vld_r   <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        chan_sh_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      shv_q_r <= sh_vld_r[sh_raddr];
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          idx_r <= '0;
          if (in_acc) begin
            ch_r   <= dec.ch;
            slot_r <= dec.slot;
            grp_r  <= dec.grp;
            val_r  <= in_write_value;
            unique case (dec.kind)
              WK_DAC: begin
                dac_r <= in_write_value[7];
                res_r <= EV_STORED;
              end
              WK_CHAN: begin
                chan_sh_r[dec.ch] <= in_write_value[5:0];
                res_r <= EV_STORED;
              end
              WK_IGN:  res_r <= EV_IGNORED;
              WK_KEY: begin
                if (dec.key_bad || (dec.ch == CH_DAC && dac_r)) begin
                  res_r <= EV_IGNORED;
                end else begin
                  res_r <= EV_STORED;
                end
              end
              default: res_r <= EV_STORED;
            endcase
          end
        end
        S_SHRD: ;
        S_SHWR: sh_vld_r[slot_r] <= 1'b1;
        S_KRD: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r != 3'd0) begin
            opw_r[rd_word] <= sh_word;
            eq_r    <= ((rd_word == 2'd0) ? (chan_snap_r[ch_r] == chan_sh_r[ch_r]) : eq_r)
                       && (sn_rdata == sh_word);
            noatk_r <= ((rd_word == 2'd0) ? 1'b1 : noatk_r) && (sh_word[20:16] == 5'd0);
            quiet_r <= ((rd_word == 2'd0) ? 1'b1 : quiet_r) && (sh_word[13:7] > LEVEL_MAX);
          end
        end
        S_KDEC: begin
          cnt_r     <= '0;
          iss_r     <= '0;
          chk_vld_r <= 1'b0;
          app_r     <= 1'b0;
          if (snap_vld_r[ch_r] && eq_r) begin
            res_r <= EV_UNCHANGED;
          end else if (noatk_r || quiet_r) begin
            res_r <= EV_SILENT;
          end
        end
        S_SRCH: begin
          chk_vld_r  <= issue;
          chk_addr_r <= iss_r[EW+1:0];
          if (issue) begin
            iss_r <= iss_r + IW'(1);
          end
          if (chk_vld_r) begin
            ok_r <= ((chk_addr_r[1:0] == 2'd0) ? (cw_rdata == chan_sh_r[ch_r]) : ok_r) && op_eq;
          end
          if (hit) begin
            res_r <= EV_MATCHED;
            idx_r <= chk_addr_r[EW+1:2];
          end else if (scan_done) begin
            if (count_r >= CW'(TABLE_ENTRIES)) begin
              res_r <= EV_FULL;
            end else begin
              res_r <= EV_ADDED;
              idx_r <= EW'(count_r);
              app_r <= 1'b1;
            end
          end
        end
        S_APP: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd3) begin
            chan_snap_r[ch_r] <= chan_sh_r[ch_r];
            snap_vld_r[ch_r]  <= 1'b1;
            if (app_r) begin
              count_r <= count_r + CW'(1);
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_res_r   <= res_r;
            out_idx_r   <= idx_ext[5:0];
            out_cnt_r   <= cnt_ext[6:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign idx_ext = IXW'(idx_r);
  assign cnt_ext = CXW'(count_r);

  assign out_valid       = out_valid_r;
  assign out_event_res   = out_res_r;
  assign out_entry_index = out_idx_r;
  assign out_entry_count = out_cnt_r;

endmodule

// File: hdl/fmrsp_chk.sv
// Port-level checker for the FM register shadow capture block, with its bind.
module fmrsp_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_event_res,
  input logic [5:0] out_entry_index,
  input logic [6:0] out_entry_count
);
  import fmrsp_pkg::*;

  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input word taken while the previous one is in flight");

  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res != EV_MATCHED && out_event_res != EV_ADDED)
      |-> out_entry_index == 6'd0)
    else $error("entry index set on an event without an entry");

  a_added_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res == EV_ADDED)
      |-> out_entry_index == 6'(out_entry_count - 7'd1))
    else $error("added entry is not the last one");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_event_res) &&
      $stable(out_entry_index) && $stable(out_entry_count)))
    else $error("stalled result word changed");

endmodule

bind fm_register_shadow_patch_capture_top fmrsp_chk u_fmrsp_chk (.*);

// File: sim/tb_top.sv
// Testbench for the FM register shadow and patch capture block.
`timescale 1ns / 1ps

module tb_top;
  import fmrsp_pkg::*;

  localparam int NTAB = TABLE_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [2:0] ev;
    logic [5:0] idx;
    logic [6:0] cnt;
  } capture_res_t;

  // Scoreboard: a shadow of the patch state that predicts each result.
  class patch_scoreboard;
    logic [OP_W-1:0] op_sh[NUM_SLOT];
    logic [CH_W-1:0] ch_sh[NUM_CH];
    logic [OP_W-1:0] op_snap[NUM_SLOT];
    logic [CH_W-1:0] ch_snap[NUM_CH];
    bit snap_ok[NUM_CH];
    logic [OP_W-1:0] tab_op[NTAB*4];
    logic [CH_W-1:0] tab_ch[NTAB];
    int count;
    bit dac_on;
    capture_res_t pending[$];
    int mismatches;

    function void clear();
      foreach (op_sh[i]) op_sh[i] = '0;
      foreach (ch_sh[i]) begin
        ch_sh[i] = '0;
        snap_ok[i] = 0;
      end
      count = 0;
      dac_on = 0;
      mismatches = 0;
    endfunction

    function bit same_as(int ch, int e);
      if (tab_ch[e] != ch_sh[ch]) return 0;
      for (int i = 0; i < 4; i++)
        if (tab_op[e*4+i] != op_sh[ch*4+i]) return 0;
      return 1;
    endfunction

    function bit same_as_snap(int ch);
      if (ch_snap[ch] != ch_sh[ch]) return 0;
      for (int i = 0; i < 4; i++)
        if (op_snap[ch*4+i] != op_sh[ch*4+i]) return 0;
      return 1;
    endfunction

    function event_t key_write(logic [7:0] v, output int idx);
      int ch;
      bit mute_a, mute_l;
      event_t r;
      idx = 0;
      case (v[2:0])
        3'd0, 3'd1, 3'd2: ch = v[2:0];
        3'd4, 3'd5, 3'd6: ch = v[2:0] - 1;
        default: return EV_IGNORED;
      endcase
      if (ch == CH_DAC && dac_on) return EV_IGNORED;
      if (v[7:4] == 4'h0) return EV_IGNORED;
      mute_a = 1;
      mute_l = 1;
      for (int i = 0; i < 4; i++) begin
        if (op_sh[ch*4+i][20:16] != 0) mute_a = 0;
        if (op_sh[ch*4+i][13:7] <= LEVEL_MAX) mute_l = 0;
      end
      if (snap_ok[ch] && same_as_snap(ch)) r = EV_UNCHANGED;
      else if (mute_a || mute_l) r = EV_SILENT;
      else begin
        r = EV_STORED;
        for (int e = 0; e < count; e++)
          if (same_as(ch, e)) begin
            r = EV_MATCHED;
            idx = e;
            break;
          end
        if (r == EV_STORED) begin
          if (count >= NTAB) r = EV_FULL;
          else begin
            for (int i = 0; i < 4; i++) tab_op[count*4+i] = op_sh[ch*4+i];
            tab_ch[count] = ch_sh[ch];
            idx = count;
            count++;
            r = EV_ADDED;
          end
        end
      end
      for (int i = 0; i < 4; i++) op_snap[ch*4+i] = op_sh[ch*4+i];
      ch_snap[ch] = ch_sh[ch];
      snap_ok[ch] = 1;
      return r;
    endfunction

    // note an accepted input word
    function void note_write(logic b, logic [7:0] a, logic [7:0] v);
      capture_res_t x;
      int idx, ch, slot;
      logic [OP_W-1:0] w;
      idx = 0;
      if (!b && a == REG_DAC) begin
        dac_on = v[7];
        x.ev = EV_STORED;
      end else if (!b && a == REG_KEY) begin
        x.ev = key_write(v, idx);
      end else if (a < REG_LO || a > REG_HI || a[1:0] == 2'd3 || a[7:4] == 4'ha) begin
        x.ev = EV_IGNORED;
      end else begin
        ch = a[1:0] + (b ? 3 : 0);
        slot = ch * 4 + a[3:2];
        w = op_sh[slot];
        case (a[7:4])
          4'h3: begin
            // detune codes 4..7 fold to 0,-1,-2,-3
            w[2:0] = v[6] ? 3'(3'd0 - {1'b0, v[5:4]}) : v[6:4];
            w[6:3] = v[3:0];
          end
          4'h4: w[13:7] = v[6:0];
          4'h5: begin
            w[15:14] = v[7:6];
            w[20:16] = v[4:0];
          end
          4'h6: w[25:21] = v[4:0];
          4'h7: w[30:26] = v[4:0];
          4'h8: begin
            w[38:35] = v[7:4];
            w[34:31] = v[3:0];
          end
          4'h9: w[42:39] = v[3:0];
          default: ch_sh[ch] = {v[5:3], v[2:0]};
        endcase
        op_sh[slot] = w;
        x.ev = EV_STORED;
      end
      x.idx = idx[5:0];
      x.cnt = count[6:0];
      pending.push_back(x);
    endfunction

    function void check(logic [2:0] ev, logic [5:0] idx, logic [6:0] cnt);
      capture_res_t x;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result ev=%0d idx=%0d cnt=%0d", ev, idx, cnt);
        return;
      end
      x = pending.pop_front();
      if (x.ev !== ev || x.idx !== idx || x.cnt !== cnt) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp ev=%0d idx=%0d cnt=%0d, got ev=%0d idx=%0d cnt=%0d",
                   x.ev, x.idx, x.cnt, ev, idx, cnt);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic in_bank = 0;
  logic [7:0] in_register_address = '0;
  logic [7:0] in_write_value = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] out_event_res;
  logic [5:0] out_entry_index;
  logic [6:0] out_entry_count;

  patch_scoreboard sb;
  int cycles = 0;
  bit hold_off = 0;    // long receiver stall requested by the stimulus
  bit stall_rand = 1;  // random receiver stalls enabled

  always #6 clk = ~clk;

  fm_register_shadow_patch_capture_top u_top (.*);

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Sample on the edge; the scoreboard sees exactly the accepted words.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check(out_event_res, out_entry_index, out_entry_count);
  end

  // Receiver: mostly short stalls, an occasional long one, and the forced hold-off.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1;
        for (int i = 0; i < 400; i++) @(posedge clk);
        hold_off = 0;
        out_stall <= 0;
      end else if (stall_rand && $urandom_range(0, 3) == 0) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  // Offer one word and wait for its acceptance; random gap first.
  // Valid stays up after acceptance until the next gap or drain.
  task automatic send_word(logic b, logic [7:0] a, logic [7:0] v, bit gaps = 1);
    int g;
    if (gaps && $urandom_range(0, 2) == 0) begin
      g = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_bank <= b;
    in_register_address <= a;
    in_write_value <= v;
    do @(posedge clk); while (in_stall);
    sb.note_write(b, a, v);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Fill channel ch with a random audible patch (all zeros when audible is 0), then key it on.
  task automatic play_patch(int ch, bit audible);
    logic b;
    logic [7:0] base;
    b = ch >= 3;
    for (int op = 0; op < 4; op++) begin
      base = 8'(ch % 3 + op * 4);
      for (int g = 3; g <= 9; g++) begin
        // a small pool of values so patches repeat and match
        if ($urandom_range(0, 2) != 0 || !audible)
          send_word(b, 8'(g * 16) + base,
                    audible ? 8'($urandom_range(0, 3) * 8'h41) : 8'h00);
      end
    end
    if ($urandom_range(0, 1)) send_word(b, 8'hb0 + 8'(ch % 3), 8'($urandom_range(0, 255)));
    send_word(0, REG_KEY, {4'($urandom_range(1, 15)), 1'b0, 3'(ch < 3 ? ch : ch + 1)});
  endtask

  initial begin
    int n_items;
    sb = new();
    sb.clear();
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: unmapped addresses, bank 1 DAC/key, DAC on/off, key codes.
    send_word(0, 8'h00, 8'hff);
    send_word(1, 8'hff, 8'h00);
    send_word(0, 8'ha4, 8'h5a);
    send_word(0, 8'h33, 8'h12);
    send_word(1, REG_KEY, 8'hf0);
    send_word(1, REG_DAC, 8'h80);
    send_word(0, REG_KEY, 8'hf0);          // all-zero patch: silent
    send_word(0, REG_KEY, 8'hf0);          // unchanged
    send_word(0, REG_KEY, 8'hf3);          // code 3
    send_word(0, REG_KEY, 8'hf7);          // code 7
    send_word(0, REG_KEY, 8'h01);          // key off
    send_word(0, REG_DAC, 8'h80);
    send_word(0, REG_KEY, 8'hf6);          // DAC channel while DAC on
    send_word(0, REG_DAC, 8'h7f);
    for (int d = 0; d < 8; d++) send_word(1, 8'h36, 8'(d << 4) | 8'h8f);  // detune codes
    send_word(1, 8'h5e, 8'hff);
    send_word(1, 8'hb2, 8'hff);
    send_word(0, REG_KEY, 8'hf6);          // added
    play_patch(1, 0);
    drain();

    // Long receiver hold-off while the sender keeps offering.
    hold_off = 1;
    for (int i = 0; i < 6; i++) play_patch($urandom_range(0, 5), 1);
    drain();

    // Random: mostly well-formed patches, some noise and silent patches.
    n_items = 0;
    while (n_items < 200) begin
      if ($urandom_range(0, 4) == 0) begin
        send_word($urandom_range(0, 1), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        n_items++;
      end else begin
        play_patch($urandom_range(0, 5), $urandom_range(0, 9) != 0);
        n_items += 20;
      end
      if ($urandom_range(0, 10) == 0) send_word(0, REG_DAC, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 60) == 0) drain();
    end
    // All levels above LEVEL_MAX on channel 2: silent.
    for (int op = 0; op < 4; op++) send_word(0, 8'h42 + 8'(op * 4), 8'hff);
    send_word(0, 8'h52, 8'h1f);
    send_word(0, REG_KEY, 8'hf2);

    drain();
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: fm_register_shadow_patch_capture_top.f
hdl/fmrsp_pkg.sv
hdl/fmrsp_ram.sv
hdl/fmrsp_decode.sv
hdl/fm_register_shadow_patch_capture_top.sv
hdl/fmrsp_chk.sv
sim/tb_top.sv
